### sv/flr_pkg.sv
// Shared constants, types and helper functions of the line rasterizer.
`default_nettype none

package flr_pkg;

	localparam int SCREEN_W     = 256;
	localparam int SCREEN_H     = 192;
	localparam int COORD_BITS   = 12;
	localparam int COLOUR_W     = 15;
	localparam int PIX_W        = COLOUR_W + 1;
	localparam int LAYER_PIXELS = SCREEN_W * SCREEN_H;
	localparam int STORE_DEPTH  = 2 * LAYER_PIXELS;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	// Pixel coordinates as computed along a line, with headroom for sums.
	localparam int PC_W         = COORD_BITS + 2;
	localparam int D_W          = COORD_BITS;
	localparam int PROD_W       = 2 * COORD_BITS + 1;
	localparam int DIV_W        = 2 * COORD_BITS;
	localparam int DCNT_W       = $clog2(DIV_W + 1);

	typedef enum logic [1:0] {
		OP_POINT,
		OP_LINE,
		OP_FILL,
		OP_READ
	} op_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_POINT,
		S_READ,
		S_RESULT,
		S_FILL,
		S_LINE,
		S_MUL1,
		S_DIV1,
		S_WAIT1,
		S_MUL2,
		S_DIV2,
		S_WAIT2,
		S_PLOT
	} state_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic clr;
		logic point_wr;
		logic rd;
		logic minor_init;
		logic mul1;
		logic mul2;
		logic div_go;
		logic div_take;
		logic plot;
	} dp_cmd_t;

	typedef struct packed {
		logic shallow;
		logic d_zero;
		logic i_last;
		logic sweep_last;
		logic div_done;
	} dp_status_t;

	function automatic logic on_screen(logic signed [PC_W-1:0] x, logic signed [PC_W-1:0] y);
		return (int'(x) >= 0) && (int'(x) < SCREEN_W) && (int'(y) >= 0) && (int'(y) < SCREEN_H);
	endfunction

	function automatic logic [ADDR_W-1:0] pix_addr(logic layer, logic [PC_W-1:0] x,
			logic [PC_W-1:0] y);
		return ADDR_W'(ADDR_W'(layer) * ADDR_W'(LAYER_PIXELS) + ADDR_W'(y) * ADDR_W'(SCREEN_W)
			+ ADDR_W'(x));
	endfunction

endpackage

`default_nettype wire

### sv/flr_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module flr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

### sv/flr_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module flr_div import flr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic signed [PROD_W-1:0] dividend,
	input  logic [D_W-1:0]           divisor,
	output logic                     done,
	output logic signed [PC_W-1:0]   quotient
);

	logic              act_q;
	logic              neg_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [D_W-1:0]    rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [PROD_W-1:0] mag;
	logic [D_W:0]      shifted;
	logic [D_W:0]      trial;
	logic              fit;

	assign mag     = dividend[PROD_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign fit     = shifted >= {1'b0, divisor};
	assign trial   = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			act_q <= 1'b1;
			cnt_q <= DCNT_W'(DIV_W);
		end else if (act_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= dividend[PROD_W-1];
			rem_q <= '0;
			quo_q <= mag[DIV_W-1:0];
		end else if (act_q && cnt_q != '0) begin
			rem_q <= fit ? trial[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fit};
		end
	end

	assign done     = act_q && (cnt_q == '0);
	assign quotient = neg_q ? -$signed(PC_W'(quo_q)) : $signed(PC_W'(quo_q));

endmodule

`default_nettype wire

### sv/flr_datapath.sv
// Datapath: command registers, line interpolation, divider and the frame store.
`default_nettype none

module flr_datapath import flr_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	output dp_status_t                   status,
	input  logic [1:0]                   operation,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	input  logic [COLOUR_W-1:0]          pixel_colour,
	input  logic                         alpha_bit,
	input  logic                         layer_select,
	output logic [PIX_W-1:0]             read_pixel
);

	logic signed [COORD_BITS-1:0] xa_q, ya_q, xb_q, yb_q;
	logic                         shallow_q;
	logic [D_W-1:0]               d_q;
	logic [D_W-1:0]               i_q;
	logic signed [PROD_W-1:0]     acc_q;
	logic signed [PC_W-1:0]       minor_q;
	logic [PIX_W-1:0]             word_q;
	logic                         layer_q;
	logic                         rd_off_q;
	logic [ADDR_W-1:0]            cnt_q;
	logic [ADDR_W-1:0]            end_q;

	logic signed [COORD_BITS:0]   dx, dy, adx, ady, dmaj;
	logic                         shallow_n, swap_n;
	logic signed [COORD_BITS-1:0] xa_n, ya_n, xb_n, yb_n;
	logic [ADDR_W-1:0]            base_n;

	logic signed [COORD_BITS-1:0] mul_a;
	logic signed [COORD_BITS:0]   mul_b;
	logic signed [PROD_W-1:0]     prod;

	logic                         div_done;
	logic signed [PC_W-1:0]       quotient;

	logic signed [PC_W-1:0]       major, px, py, sx, sy;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_addr;
	logic [PIX_W-1:0]             ram_wdata, ram_rdata;

	// Endpoint ordering for a new command.
	always_comb begin
		dx        = (COORD_BITS+1)'(x_end) - (COORD_BITS+1)'(x_start);
		dy        = (COORD_BITS+1)'(y_end) - (COORD_BITS+1)'(y_start);
		adx       = dx[COORD_BITS] ? -dx : dx;
		ady       = dy[COORD_BITS] ? -dy : dy;
		shallow_n = $unsigned(ady) <= $unsigned(adx);
		swap_n    = (op_t'(operation) == OP_LINE) &&
			(shallow_n ? (x_start > x_end) : (y_start > y_end));
		xa_n      = swap_n ? x_end : x_start;
		ya_n      = swap_n ? y_end : y_start;
		xb_n      = swap_n ? x_start : x_end;
		yb_n      = swap_n ? y_start : y_end;
		dmaj      = shallow_n ? ((COORD_BITS+1)'(xb_n) - (COORD_BITS+1)'(xa_n))
			: ((COORD_BITS+1)'(yb_n) - (COORD_BITS+1)'(ya_n));
		base_n    = ADDR_W'(ADDR_W'(layer_select) * ADDR_W'(LAYER_PIXELS));
	end

	// One shared multiplier for both interpolation products.
	always_comb begin
		if (cmd.mul1) begin
			mul_a = shallow_q ? ya_q : xa_q;
			mul_b = $signed({1'b0, d_q - i_q});
		end else begin
			mul_a = shallow_q ? yb_q : xb_q;
			mul_b = $signed({1'b0, i_q});
		end
		prod = mul_a * mul_b;
	end

	flr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (acc_q),
		.divisor  (d_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		major = PC_W'(shallow_q ? xa_q : ya_q) + $signed(PC_W'(i_q));
		px    = shallow_q ? major : minor_q;
		py    = shallow_q ? minor_q : major;
		sx    = PC_W'(xa_q);
		sy    = PC_W'(ya_q);
	end

	// Frame store port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pix_addr(layer_q, sx, sy);
		ram_wdata = cmd.clr ? '0 : word_q;
		if (cmd.sweep) begin
			ram_we   = 1'b1;
			ram_addr = cnt_q;
		end else if (cmd.plot) begin
			ram_we   = on_screen(px, py);
			ram_addr = pix_addr(layer_q, px, py);
		end else if (cmd.point_wr) begin
			ram_we   = on_screen(sx, sy);
		end
	end

	flr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			end_q <= ADDR_W'(STORE_DEPTH - 1);
		end else if (cmd.load) begin
			cnt_q <= base_n;
			end_q <= base_n + ADDR_W'(LAYER_PIXELS - 1);
		end else if (cmd.sweep) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xa_q      <= xa_n;
			ya_q      <= ya_n;
			xb_q      <= xb_n;
			yb_q      <= yb_n;
			shallow_q <= shallow_n;
			d_q       <= D_W'(dmaj);
			i_q       <= '0;
			word_q    <= {alpha_bit, pixel_colour};
			layer_q   <= layer_select;
		end
		if (cmd.plot) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.mul1) begin
			acc_q <= prod;
		end else if (cmd.mul2) begin
			acc_q <= shallow_q ? prod : acc_q + prod;
		end
		if (cmd.minor_init) begin
			minor_q <= PC_W'(shallow_q ? ya_q : xa_q);
		end else if (cmd.mul1) begin
			minor_q <= '0;
		end else if (cmd.div_take) begin
			minor_q <= minor_q + quotient;
		end
		if (cmd.rd) begin
			rd_off_q <= !on_screen(sx, sy);
		end
	end

	assign read_pixel = rd_off_q ? '0 : ram_rdata;

	assign status.shallow    = shallow_q;
	assign status.d_zero     = (d_q == '0);
	assign status.i_last     = (i_q == d_q);
	assign status.sweep_last = (cnt_q == end_q);
	assign status.div_done   = div_done;

endmodule

`default_nettype wire

### sv/flr_ctrl.sv
// Controller state machine sequencing the datapath for each request.
`default_nettype none

module flr_ctrl import flr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] operation,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       result_valid
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (status.sweep_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					unique case (op_t'(operation))
						OP_POINT: state_n = S_POINT;
						OP_LINE:  state_n = S_LINE;
						OP_FILL:  state_n = S_FILL;
						OP_READ:  state_n = S_READ;
						default:  state_n = S_IDLE;
					endcase
				end
			end
			S_POINT:  state_n = S_IDLE;
			S_READ:   state_n = S_RESULT;
			S_RESULT: state_n = S_IDLE;
			S_FILL: begin
				if (status.sweep_last) state_n = S_IDLE;
			end
			S_LINE:   state_n = status.d_zero ? S_PLOT : S_MUL1;
			S_MUL1:   state_n = status.shallow ? S_DIV1 : S_MUL2;
			S_DIV1:   state_n = S_WAIT1;
			S_WAIT1: begin
				if (status.div_done) state_n = S_MUL2;
			end
			S_MUL2:   state_n = S_DIV2;
			S_DIV2:   state_n = S_WAIT2;
			S_WAIT2: begin
				if (status.div_done) state_n = S_PLOT;
			end
			S_PLOT:   state_n = status.i_last ? S_IDLE : S_MUL1;
			default:  state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		busy         = 1'b1;
		result_valid = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				cmd.clr   = 1'b1;
			end
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_POINT:  cmd.point_wr = 1'b1;
			S_READ:   cmd.rd = 1'b1;
			S_RESULT: result_valid = 1'b1;
			S_FILL:   cmd.sweep = 1'b1;
			S_LINE:   cmd.minor_init = 1'b1;
			S_MUL1:   cmd.mul1 = 1'b1;
			S_DIV1:   cmd.div_go = 1'b1;
			S_WAIT1:  cmd.div_take = status.div_done;
			S_MUL2:   cmd.mul2 = 1'b1;
			S_DIV2:   cmd.div_go = 1'b1;
			S_WAIT2:  cmd.div_take = status.div_done;
			S_PLOT:   cmd.plot = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### sv/framebuffer_line_rasterizer.sv
// Top level of the two-layer framebuffer line rasterizer.
`default_nettype none

// A request is accepted on a rising edge where start is high and busy is low.
// The request carries an operation (point, line, fill layer, read pixel), two
// signed endpoints, a 15-bit colour with an alpha flag, and the target layer.
// Only a read request produces a result: read_pixel is shown for exactly one
// cycle with result_valid high, once the frame store has returned the word addressed in the read state.
// The receiver cannot stall, so the result is simply presented and dropped.
// Busy stays high while a request is being worked on; one request at a time.
// A fill writes one pixel per cycle through the single port of the frame store,
// covering all 49152 pixels of the target layer. A line loops over its major
// axis with one multiplier and one iterative divider that produces one quotient
// bit per cycle; each pixel needs two divisions on a shallow line and one on a
// steep line, and a line plots length + 1 pixels. After reset the block clears
// both layers, one word per cycle, all 98304 words; busy is high during this
// clearing pass and no request is taken.

module framebuffer_line_rasterizer import flr_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   operation,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	input  logic [COLOUR_W-1:0]          pixel_colour,
	input  logic                         alpha_bit,
	input  logic                         layer_select,
	output logic                         result_valid,
	output logic [PIX_W-1:0]             read_pixel
);

	// Commands flow from the controller to the datapath; status flows back.
	dp_cmd_t    cmd;
	dp_status_t status;

	flr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.operation    (operation),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	flr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.operation    (operation),
		.x_start      (x_start),
		.y_start      (y_start),
		.x_end        (x_end),
		.y_end        (y_end),
		.pixel_colour (pixel_colour),
		.alpha_bit    (alpha_bit),
		.layer_select (layer_select),
		.read_pixel   (read_pixel)
	);

	// Every accepted request makes busy high in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without entering a working state");

	// A result only appears while the block is still busy with the read.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe while idle");

	// The result strobe lasts one cycle, and the block is free right after it.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid && !busy)
		else $error("result strobe not followed by idle");

endmodule

`default_nettype wire
